@@ src/asa_pkg.sv @@
// ----------------------------------------------------------------------------
// asa_pkg: shared types, constants and the level threshold function
// Holds the input stage item, the configuration bundle and the compile-time
// computation of the peak thresholds used by the level meter.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam int unsigned TICKS_PER_SECOND = 10;

    localparam int unsigned GATE_W    = 7;
    localparam int unsigned DELAY_W   = 12;
    localparam int unsigned LEVEL_W   = 7;
    localparam int unsigned PEAK_W    = 15;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned PRES_W    = 7;

    localparam int unsigned DELAY_MAX = (1 << DELAY_W) - 1;
    localparam int unsigned SIL_MAX   = DELAY_MAX * TICKS_PER_SECOND + 1;
    localparam int unsigned SIL_W     = $clog2(SIL_MAX + 2);

    localparam int unsigned SILENT_PEAK     = 150;
    localparam int unsigned LEVEL_OFFSET    = 90;
    localparam int unsigned LEVEL_MAX       = 99;
    localparam int unsigned PRESENCE_MAX    = 100;
    localparam int unsigned PRESENCE_MIN_ON = 50;
    localparam logic [63:0] LOG_SCALE_Q24   = 64'd215148968;

    // register indexes on the APB port (byte address is index times four)
    localparam logic [1:0] REG_GATE   = 2'd0;
    localparam logic [1:0] REG_DELAY  = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    // operation codes carried on s_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // result kinds carried on m_tuser
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic [GATE_W-1:0]  gate;
        logic [DELAY_W-1:0] delay;
        logic               enabled;
    } cfg_t;

    // item handed from the input stage to the result stage
    typedef struct packed {
        logic              op;
        logic [PEAK_W-1:0] peak;
        logic              in_window;
    } item_t;

    // integer part of 42.6*log10(p) in the Q24 log2 form; p in 1..32767
    function automatic logic [63:0] level_whole(input int unsigned p);
        int unsigned n;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lg;
        n    = 0;
        frac = 64'd0;
        while (n < 15 && (p >> (n + 1)) != 0)
            n++;
        m = 64'(p) << (30 - n);
        for (int i = 0; i < 24; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        lg = (64'(n) << 24) | frac;
        return (lg * LOG_SCALE_Q24) >> 48;
    endfunction

    // smallest peak from SILENT_PEAK up whose raw level reaches lvl; 32768 if none does
    function automatic logic [15:0] level_thresh(input int unsigned lvl);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = SILENT_PEAK;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (level_whole(mid) >= 64'(LEVEL_OFFSET + lvl))
                hi = mid;
            else
                lo = mid + 1;
        end
        return 16'(lo);
    endfunction

endpackage

@@ src/asa_cfg.sv @@
// ----------------------------------------------------------------------------
// asa_cfg: configuration register file
// APB-style slave holding gate, delay and monitor enable.
// ----------------------------------------------------------------------------
module asa_cfg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output asa_pkg::cfg_t cfg
);

    localparam logic [asa_pkg::GATE_W-1:0]  GATE_RESET  = 7'd10;
    localparam logic [asa_pkg::DELAY_W-1:0] DELAY_RESET = 12'd10;

    asa_pkg::cfg_t cfg_reg;
    asa_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                asa_pkg::REG_GATE:   cfg_next.gate    = pwdata[asa_pkg::GATE_W-1:0];
                asa_pkg::REG_DELAY:  cfg_next.delay   = pwdata[asa_pkg::DELAY_W-1:0];
                asa_pkg::REG_ENABLE: cfg_next.enabled = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            asa_pkg::REG_GATE:   prdata = 32'(cfg_reg.gate);
            asa_pkg::REG_DELAY:  prdata = 32'(cfg_reg.delay);
            asa_pkg::REG_ENABLE: prdata = 32'(cfg_reg.enabled);
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate    <= GATE_RESET;
            cfg_reg.delay   <= DELAY_RESET;
            cfg_reg.enabled <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/asa_front.sv @@
// ----------------------------------------------------------------------------
// asa_front: input stage
// Tracks the running frame peak and registers frame-end and tick beats.
// ----------------------------------------------------------------------------
module asa_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [asa_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          op,
    input  logic                          frame_end,
    input  logic                          in_window,
    input  logic                          advance,
    output logic                          item_valid,
    output asa_pkg::item_t                item
);

    logic [asa_pkg::PEAK_W-1:0] peak_reg;
    logic [asa_pkg::PEAK_W-1:0] peak_next;
    logic [asa_pkg::PEAK_W-1:0] peak_cur;
    logic                       valid_reg;
    logic                       valid_next;
    asa_pkg::item_t             item_reg;
    asa_pkg::item_t             item_next;
    logic                       accept;
    logic                       emits;

    assign s_tready   = !valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign emits      = (op == asa_pkg::OP_TICK) || frame_end;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // only non-negative samples can raise the peak
    always_comb
    begin
        peak_cur = peak_reg;
        if (!sample[asa_pkg::SAMPLE_W-1] && (sample[asa_pkg::PEAK_W-1:0] > peak_reg))
            peak_cur = sample[asa_pkg::PEAK_W-1:0];
    end

    always_comb
    begin
        peak_next  = peak_reg;
        valid_next = valid_reg && !advance;
        item_next  = item_reg;
        if (accept)
        begin
            if (op == asa_pkg::OP_SAMPLE)
                peak_next = frame_end ? '0 : peak_cur;
            if (emits)
            begin
                valid_next          = 1'b1;
                item_next.op        = op;
                item_next.peak      = (op == asa_pkg::OP_SAMPLE) ? peak_cur : '0;
                item_next.in_window = in_window;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg  <= peak_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

@@ src/asa_back.sv @@
// ----------------------------------------------------------------------------
// asa_back: result stage
// Converts the frame peak to a level, qualifies it by presence, runs the
// silence counter on ticks and holds the result beat.
// ----------------------------------------------------------------------------
module asa_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  asa_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  asa_pkg::item_t item,
    output logic           advance,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata,
    output logic           m_tuser
);

    localparam int unsigned NLVL = asa_pkg::LEVEL_MAX;

    logic [NLVL-1:0]                 thermo;
    logic [NLVL-1:0]                 top_hit;
    logic [asa_pkg::LEVEL_W-1:0]     raw_level;
    logic [asa_pkg::LEVEL_W-1:0]     frame_level;
    logic [asa_pkg::PRES_W-1:0]      pres_reg;
    logic [asa_pkg::PRES_W-1:0]      pres_next;
    logic [asa_pkg::PRES_W-1:0]      pres_upd;
    logic [asa_pkg::LEVEL_W-1:0]     held_reg;
    logic [asa_pkg::LEVEL_W-1:0]     held_next;
    logic [asa_pkg::SIL_W-1:0]       sil_reg;
    logic [asa_pkg::SIL_W-1:0]       sil_next;
    logic [asa_pkg::SIL_W:0]         sil_inc;
    logic [asa_pkg::SIL_W-1:0]       sil_cnt;
    logic [asa_pkg::SIL_W-1:0]       delay_ticks;
    logic [asa_pkg::DELAY_W-1:0]     delay_eff;
    logic                            sounding;
    logic                            raised;
    logic                            cleared;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [23:0]                     out_data_reg;
    logic [23:0]                     out_data_next;
    logic                            out_kind_reg;
    logic                            out_kind_next;
    logic                            take;

    assign advance  = !out_valid_reg || m_tready;
    assign take     = advance && item_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // threshold compares; raw level is the count of thresholds reached
    for (genvar l = 1; l <= NLVL; l++)
    begin : g_thresh
        assign thermo[l-1] = ({1'b0, item.peak} >= asa_pkg::level_thresh(l));
    end

    // the compares form a thermometer code: mark its top set bit
    assign top_hit = thermo & ~{1'b0, thermo[NLVL-1:1]};

    always_comb
    begin
        raw_level = '0;
        for (int i = 0; i < NLVL; i++)
            if (top_hit[i])
                raw_level = raw_level | asa_pkg::LEVEL_W'(i + 1);
    end

    always_comb
    begin
        pres_upd = pres_reg;
        if (raw_level <= asa_pkg::LEVEL_W'(1))
        begin
            if (pres_reg != '0)
                pres_upd = pres_reg - asa_pkg::PRES_W'(1);
        end
        else if (pres_reg < asa_pkg::PRES_W'(asa_pkg::PRESENCE_MAX))
        begin
            pres_upd = pres_reg + asa_pkg::PRES_W'(1);
        end
        frame_level = (pres_upd < asa_pkg::PRES_W'(asa_pkg::PRESENCE_MIN_ON)) ? '0 : raw_level;
    end

    // silence counter for one tick
    always_comb
    begin
        delay_eff   = (cfg.delay == '0) ? asa_pkg::DELAY_W'(1) : cfg.delay;
        delay_ticks = asa_pkg::SIL_W'(delay_eff) * asa_pkg::SIL_W'(asa_pkg::TICKS_PER_SECOND);
        sounding    = (held_reg >= cfg.gate) || !(cfg.enabled && item.in_window);
        cleared     = 1'b0;
        sil_inc     = {1'b0, sil_reg} + (asa_pkg::SIL_W+1)'(1);
        if (sounding)
        begin
            cleared = (sil_reg >= delay_ticks);
            sil_inc = '0;
        end
        raised  = (sil_inc == {1'b0, delay_ticks});
        // hold at delay_ticks plus one
        if (sil_inc > {1'b0, delay_ticks})
            sil_cnt = delay_ticks + asa_pkg::SIL_W'(1);
        else
            sil_cnt = sil_inc[asa_pkg::SIL_W-1:0];
    end

    always_comb
    begin
        pres_next      = pres_reg;
        held_next      = held_reg;
        sil_next       = sil_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (item.op == asa_pkg::OP_SAMPLE)
            begin
                pres_next     = pres_upd;
                held_next     = frame_level;
                out_kind_next = asa_pkg::KIND_FRAME;
                out_data_next = {1'b0, 1'b0, item.peak, frame_level};
            end
            else
            begin
                sil_next      = sil_cnt;
                out_kind_next = asa_pkg::KIND_TICK;
                out_data_next = {cleared, raised, asa_pkg::PEAK_W'(0), held_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pres_reg      <= '0;
            held_reg      <= '0;
            sil_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pres_reg      <= pres_next;
            held_reg      <= held_next;
            sil_reg       <= sil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

endmodule

@@ src/audio_silence_alarm_top.sv @@
// ----------------------------------------------------------------------------
// audio_silence_alarm_top: frame level meter with silence alarm
// Input stage, result stage and configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries audio samples (s_tuser 0) and 100 ms ticks
//   (s_tuser 1). s_tlast marks the last sample of a frame. Samples without
//   s_tlast only update the running peak and give no result beat.
//   Each frame-end sample gives one frame beat (level and raw peak) and each
//   tick gives one alarm beat on the master stream, in input order.
//   Path: an accepted beat is registered in the input register, then in
//   the result register, before it is valid on the master stream.
//   Throughput: one beat per cycle while the receiver does not stall; the level is found by threshold compares
//   in the result stage and the silence counter steps once per tick.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more beat; s_tready then falls.
//   Reset clears peak, presence, held level and silence count and loads the
//   register defaults: gate 10, delay 10 s, monitoring off.
//   Configuration is written over the APB port while the streams are idle.
// ----------------------------------------------------------------------------
module audio_silence_alarm_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] sample, [16] in_time_window, [23:17] zero
    input  logic        s_tlast,   // frame_end
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] level, [21:7] peak, [22] alarm_raised,
                                   // [23] alarm_cleared
    output logic        m_tuser,   // result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    asa_pkg::cfg_t  cfg;
    asa_pkg::item_t item;
    logic           item_valid;
    logic           advance;

    asa_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asa_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sample     (s_tdata[15:0]),
        .op         (s_tuser),
        .frame_end  (s_tlast),
        .in_window  (s_tdata[16]),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    asa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ src/asa_checker.sv @@
// ----------------------------------------------------------------------------
// asa_checker: port-level checks on the result stream
// Bound to the top level; watches the master stream only.
// ----------------------------------------------------------------------------
module asa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // frame beats carry no alarm flags
    a_frame_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == asa_pkg::KIND_FRAME) |-> m_tdata[23:22] == 2'b00)
        else $error("alarm flag on frame beat");

    // tick beats carry a zero peak
    a_tick_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == asa_pkg::KIND_TICK) |-> m_tdata[21:7] == 15'd0)
        else $error("peak on tick beat");

    // level within range
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] <= 7'(asa_pkg::LEVEL_MAX))
        else $error("level out of range");

    // raise and clear are exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[22] && m_tdata[23]))
        else $error("alarm raised and cleared on one tick");

endmodule

bind audio_silence_alarm_top asa_checker u_asa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
